FILE: sv/hpt_pkg.sv
package hpt_pkg;

    localparam int CODE_W    = 8;
    localparam int NUM_LANES = 3;
    localparam int Y_W       = 17;
    localparam int Q_BITS    = 17;
    localparam int LIN_LIMIT = 205;
    localparam int LIN_MUL   = 329460;
    localparam int LIN_DIV   = 6553600;
    localparam int ENC_MUL   = 1055;
    localparam int ENC_OFS   = 3604480;
    localparam int RECIP_1K  = 536871;
    localparam int RECIP_SH  = 29;

    typedef logic [Y_W-1:0] t_y;

    typedef struct packed {
        logic [2:0] qsh;
        logic [3:0] j;
    } t_oct;

    // m^(5/12) at m = 1 + i/8, Q16
    function automatic logic [16:0] mant_pow(input logic [3:0] idx);
        logic [16:0] v;
        case (idx)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd68832;
            4'd2:    v = 17'd71921;
            4'd3:    v = 17'd74835;
            4'd4:    v = 17'd77598;
            4'd5:    v = 17'd80230;
            4'd6:    v = 17'd82746;
            4'd7:    v = 17'd85159;
            4'd8:    v = 17'd87480;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // 2^(-j/12), Q16
    function automatic logic [16:0] semitone(input logic [3:0] j);
        logic [16:0] v;
        case (j)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61858;
            4'd2:    v = 17'd58386;
            4'd3:    v = 17'd55109;
            4'd4:    v = 17'd52016;
            4'd5:    v = 17'd49097;
            4'd6:    v = 17'd46341;
            4'd7:    v = 17'd43740;
            4'd8:    v = 17'd41285;
            4'd9:    v = 17'd38968;
            4'd10:   v = 17'd36781;
            4'd11:   v = 17'd34717;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // 5*(16-e) split into 12*qsh + j
    function automatic t_oct oct_split(input logic [4:0] e);
        t_oct v;
        case (e)
            5'd16:   v = '{qsh: 3'd0, j: 4'd0};
            5'd15:   v = '{qsh: 3'd0, j: 4'd5};
            5'd14:   v = '{qsh: 3'd0, j: 4'd10};
            5'd13:   v = '{qsh: 3'd1, j: 4'd3};
            5'd12:   v = '{qsh: 3'd1, j: 4'd8};
            5'd11:   v = '{qsh: 3'd2, j: 4'd1};
            5'd10:   v = '{qsh: 3'd2, j: 4'd6};
            5'd9:    v = '{qsh: 3'd2, j: 4'd11};
            5'd8:    v = '{qsh: 3'd3, j: 4'd4};
            5'd7:    v = '{qsh: 3'd3, j: 4'd9};
            5'd6:    v = '{qsh: 3'd4, j: 4'd2};
            5'd5:    v = '{qsh: 3'd4, j: 4'd7};
            5'd4:    v = '{qsh: 3'd5, j: 4'd0};
            5'd3:    v = '{qsh: 3'd5, j: 4'd5};
            5'd2:    v = '{qsh: 3'd5, j: 4'd10};
            5'd1:    v = '{qsh: 3'd6, j: 4'd3};
            5'd0:    v = '{qsh: 3'd6, j: 4'd8};
            default: v = '{qsh: 3'd0, j: 4'd0};
        endcase
        return v;
    endfunction

endpackage

FILE: sv/hpt_if.sv
interface hpt_lin_if #(parameter int WIDTH = 24);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] red_linear;
    logic [WIDTH-1:0] green_linear;
    logic [WIDTH-1:0] blue_linear;

    modport source(output valid, red_linear, green_linear, blue_linear, input ready);
    modport sink(input valid, red_linear, green_linear, blue_linear, output ready);
endinterface

interface hpt_code_if;
    import hpt_pkg::*;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] red_code;
    logic [CODE_W-1:0] green_code;
    logic [CODE_W-1:0] blue_code;

    modport source(output valid, red_code, green_code, blue_code, input ready);
    modport sink(input valid, red_code, green_code, blue_code, output ready);
endinterface

FILE: sv/hdr_pixel_tonemap_srgb.sv
// channel   dir  handshake        word
// i_pix     in   valid / ready    red_linear, green_linear, blue_linear (Q8.16)
// o_pix     out  valid / ready    red_code, green_code, blue_code (8 bit)
//
// one pixel per cycle sustained while output words are taken
// latency is set by the 17-step restoring divider of the tone curve, one
// quotient bit per stage, plus the power and encode stages around it
// the whole pipeline holds while an output word waits and is not taken
// reset is synchronous, active low, and clears only the valid bits
module hdr_pixel_tonemap_srgb #(
    parameter int INPUT_FRAC_BITS = 16,
    parameter int INPUT_INT_BITS  = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hpt_lin_if.sink    i_pix,
    hpt_code_if.source o_pix
);
    import hpt_pkg::*;

    localparam int F     = INPUT_FRAC_BITS;
    localparam int W     = INPUT_INT_BITS + INPUT_FRAC_BITS;
    localparam int XW    = F + 3;
    localparam int XXW   = 2 * XW;
    localparam int DW    = 2 * F + 14;
    localparam int ST_A  = 0;
    localparam int ST_B  = 1;
    localparam int ST_C  = 2;
    localparam int ST_D  = 3;
    localparam int ST_E  = ST_D + Q_BITS;
    localparam int ST_F  = ST_E + 1;
    localparam int ST_G  = ST_F + 1;
    localparam int ST_H  = ST_G + 1;
    localparam int ST_I  = ST_H + 1;
    localparam int ST_J  = ST_I + 1;
    localparam int ST_K  = ST_J + 1;
    localparam int ST_L  = ST_K + 1;
    localparam int NSTG  = ST_L + 1;
    localparam logic [Y_W-1:0] Y_ONE = Y_W'(65536);

    logic            en;
    logic [NSTG-1:0] r_vld;
    logic [W-1:0]    lin [NUM_LANES];

    assign lin[0] = i_pix.red_linear;
    assign lin[1] = i_pix.green_linear;
    assign lin[2] = i_pix.blue_linear;

    // global advance: the last stage is the output register
    assign en          = !r_vld[NSTG-1] || o_pix.ready;
    assign i_pix.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_pix.valid};
        end
    end

    // stage A: range split
    logic [XW-1:0] xa_n [NUM_LANES];
    logic          biga_n [NUM_LANES];
    logic [XW-1:0] r_xa [NUM_LANES];
    logic          r_biga [NUM_LANES];

    generate
        if (W > XW) begin : g_wide
            always_comb begin
                for (int c = 0; c < NUM_LANES; c++) begin
                    biga_n[c] = |lin[c][W-1:XW];
                    xa_n[c]   = lin[c][XW-1:0];
                end
            end
        end else begin : g_narrow
            always_comb begin
                for (int c = 0; c < NUM_LANES; c++) begin
                    biga_n[c] = 1'b0;
                    xa_n[c]   = XW'(lin[c]);
                end
            end
        end
    endgenerate

    // stage B: square
    logic [XXW-1:0] r_xx [NUM_LANES];
    logic [XW-1:0]  r_xb [NUM_LANES];
    logic           r_bigb [NUM_LANES];
    // stage C: numerator and denominator
    logic [DW-1:0]  r_num [NUM_LANES];
    logic [DW-1:0]  r_den [NUM_LANES];
    logic           r_bigc [NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NUM_LANES; c++) begin
                r_xa[c]   <= xa_n[c];
                r_biga[c] <= biga_n[c];
                r_xx[c]   <= XXW'(r_xa[c]) * XXW'(r_xa[c]);
                r_xb[c]   <= r_xa[c];
                r_bigb[c] <= r_biga[c];
                r_num[c]  <= DW'(r_xx[c]) * DW'(251) + (DW'(r_xb[c]) << F) * DW'(3);
                r_den[c]  <= DW'(r_xx[c]) * DW'(243) + (DW'(r_xb[c]) << F) * DW'(59)
                             + (DW'(14) << (2 * F));
                r_bigc[c] <= r_bigb[c];
            end
        end
    end

    // stages D: restoring divider, one quotient bit per stage
    logic [DW-1:0]     r_drem [Q_BITS][NUM_LANES];
    logic [DW-1:0]     r_dden [Q_BITS][NUM_LANES];
    logic [Q_BITS-1:0] r_dq   [Q_BITS][NUM_LANES];
    logic              r_dbig [Q_BITS][NUM_LANES];

    generate
        for (genvar k = 0; k < Q_BITS; k++) begin : g_div
            logic [DW:0]       trial [NUM_LANES];
            logic              ge    [NUM_LANES];
            logic [DW-1:0]     rem_in [NUM_LANES];
            logic [DW-1:0]     den_in [NUM_LANES];
            logic [Q_BITS-1:0] q_in   [NUM_LANES];
            logic              big_in [NUM_LANES];

            always_comb begin
                for (int c = 0; c < NUM_LANES; c++) begin
                    if (k == 0) begin
                        rem_in[c] = r_num[c];
                        den_in[c] = r_den[c];
                        q_in[c]   = '0;
                        big_in[c] = r_bigc[c];
                        trial[c]  = {1'b0, rem_in[c]};
                    end else begin
                        rem_in[c] = r_drem[(k > 0) ? k - 1 : 0][c];
                        den_in[c] = r_dden[(k > 0) ? k - 1 : 0][c];
                        q_in[c]   = r_dq[(k > 0) ? k - 1 : 0][c];
                        big_in[c] = r_dbig[(k > 0) ? k - 1 : 0][c];
                        trial[c]  = {rem_in[c], 1'b0};
                    end
                    ge[c] = trial[c] >= {1'b0, den_in[c]};
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    for (int c = 0; c < NUM_LANES; c++) begin
                        r_drem[k][c] <= ge[c] ? DW'(trial[c] - {1'b0, den_in[c]})
                                              : DW'(trial[c]);
                        r_dden[k][c] <= den_in[c];
                        r_dq[k][c]   <= {q_in[c][Q_BITS-2:0], ge[c]};
                        r_dbig[k][c] <= big_in[c];
                    end
                end
            end
        end
    endgenerate

    // stage E: clamp to 1.0
    t_y r_y [NUM_LANES];

    // stage F: octave and mantissa fraction
    logic [4:0]  e_n    [NUM_LANES];
    logic [32:0] norm_n [NUM_LANES];
    logic [4:0]  r_ef   [NUM_LANES];
    logic [15:0] r_frac [NUM_LANES];
    logic        r_smf  [NUM_LANES];
    logic [7:0]  r_y8f  [NUM_LANES];

    always_comb begin
        for (int c = 0; c < NUM_LANES; c++) begin
            e_n[c] = 5'd0;
            for (int b = 0; b < Y_W; b++) begin
                if (r_y[c][b]) begin
                    e_n[c] = 5'(b);
                end
            end
            norm_n[c] = 33'(r_y[c]) << (5'd16 - e_n[c]);
        end
    end

    // stage G: table lookup and interpolation product
    logic [3:0]  seg_n  [NUM_LANES];
    logic [16:0] lo_n   [NUM_LANES];
    logic [16:0] hi_n   [NUM_LANES];
    logic [16:0] r_lo   [NUM_LANES];
    logic [24:0] r_ip   [NUM_LANES];
    t_oct        r_octg [NUM_LANES];
    logic        r_smg  [NUM_LANES];
    logic [7:0]  r_y8g  [NUM_LANES];

    always_comb begin
        for (int c = 0; c < NUM_LANES; c++) begin
            seg_n[c] = {1'b0, r_frac[c][15:13]};
            lo_n[c]  = mant_pow(seg_n[c]);
            hi_n[c]  = mant_pow(seg_n[c] + 4'd1);
        end
    end

    // stage H: interpolated mantissa power, linear segment product
    logic [16:0] r_mp   [NUM_LANES];
    t_oct        r_octh [NUM_LANES];
    logic        r_smh  [NUM_LANES];
    logic [26:0] r_linp [NUM_LANES];

    // stage I: octave scaling product, linear code
    logic [3:0]  lin_n  [NUM_LANES];
    logic [33:0] r_pw   [NUM_LANES];
    logic [2:0]  r_qshi [NUM_LANES];
    logic        r_smi  [NUM_LANES];
    logic [3:0]  r_lini [NUM_LANES];

    always_comb begin
        for (int c = 0; c < NUM_LANES; c++) begin
            lin_n[c] = 4'd0;
            for (int k = 1; k <= 10; k++) begin
                lin_n[c] = lin_n[c] + 4'(r_linp[c] >= 27'(k * LIN_DIV));
            end
        end
    end

    // stage J: 1.055 * p - 0.055
    logic [16:0] p_n    [NUM_LANES];
    logic [26:0] a_n    [NUM_LANES];
    logic [26:0] r_d    [NUM_LANES];
    logic        r_smj  [NUM_LANES];
    logic [3:0]  r_linj [NUM_LANES];

    always_comb begin
        for (int c = 0; c < NUM_LANES; c++) begin
            p_n[c] = 17'(r_pw[c] >> (6'd16 + 6'(r_qshi[c])));
            a_n[c] = 27'(p_n[c]) * 27'(ENC_MUL);
        end
    end

    // stage K: scale by 255, drop the Q16 fraction
    logic [18:0] r_u    [NUM_LANES];
    logic        r_smk  [NUM_LANES];
    logic [3:0]  r_link [NUM_LANES];

    // stage L: divide by 1000 through the reciprocal, saturate, select
    logic [38:0]       rq_n   [NUM_LANES];
    logic [9:0]        cq_n   [NUM_LANES];
    logic [CODE_W-1:0] code_n [NUM_LANES];
    logic [CODE_W-1:0] r_code [NUM_LANES];

    always_comb begin
        for (int c = 0; c < NUM_LANES; c++) begin
            rq_n[c] = (39'(r_u[c]) * 39'(RECIP_1K)) >> RECIP_SH;
            cq_n[c] = rq_n[c][9:0];
            if (r_smk[c]) begin
                code_n[c] = CODE_W'(r_link[c]);
            end else if (cq_n[c] > 10'd255) begin
                code_n[c] = CODE_W'(255);
            end else begin
                code_n[c] = cq_n[c][CODE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NUM_LANES; c++) begin
                if (r_dbig[Q_BITS-1][c]) begin
                    r_y[c] <= Y_ONE;
                end else if (r_dq[Q_BITS-1][c][16] && |r_dq[Q_BITS-1][c][15:0]) begin
                    r_y[c] <= Y_ONE;
                end else begin
                    r_y[c] <= r_dq[Q_BITS-1][c];
                end

                r_ef[c]   <= e_n[c];
                r_frac[c] <= norm_n[c][15:0];
                r_smf[c]  <= r_y[c] <= Y_W'(LIN_LIMIT);
                r_y8f[c]  <= r_y[c][7:0];

                r_lo[c]   <= lo_n[c];
                r_ip[c]   <= 25'(12'(hi_n[c] - lo_n[c])) * 25'(r_frac[c][12:0]);
                r_octg[c] <= oct_split(r_ef[c]);
                r_smg[c]  <= r_smf[c];
                r_y8g[c]  <= r_y8f[c];

                r_mp[c]   <= r_lo[c] + 17'(r_ip[c] >> 13);
                r_octh[c] <= r_octg[c];
                r_smh[c]  <= r_smg[c];
                r_linp[c] <= 27'(r_y8g[c]) * 27'(LIN_MUL);

                r_pw[c]   <= 34'(r_mp[c]) * 34'(semitone(r_octh[c].j));
                r_qshi[c] <= r_octh[c].qsh;
                r_smi[c]  <= r_smh[c];
                r_lini[c] <= lin_n[c];

                r_d[c]    <= (a_n[c] > 27'(ENC_OFS)) ? a_n[c] - 27'(ENC_OFS) : 27'd0;
                r_smj[c]  <= r_smi[c];
                r_linj[c] <= r_lini[c];

                r_u[c]    <= 19'((35'(r_d[c]) * 35'(255)) >> 16);
                r_smk[c]  <= r_smj[c];
                r_link[c] <= r_linj[c];

                r_code[c] <= code_n[c];
            end
        end
    end

    assign o_pix.valid      = r_vld[ST_L];
    assign o_pix.red_code   = r_code[0];
    assign o_pix.green_code = r_code[1];
    assign o_pix.blue_code  = r_code[2];

    // a waiting output word holds the whole pipeline
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.ready) |-> !i_pix.ready)
        else $error("input taken while output word waits");

    // an accepted word enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_vld[ST_A])
        else $error("accepted word lost at entry");

    // tone curve output never exceeds 1.0
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_E] |-> (r_y[0] <= Y_ONE) && (r_y[1] <= Y_ONE) && (r_y[2] <= Y_ONE))
        else $error("tone curve above one");

    // a held stage keeps its word when stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && $past(i_rst_n)) |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

endmodule

FILE: tb/hdr_pixel_tonemap_srgb_tb.sv
`timescale 1ns / 100ps

module hdr_pixel_tonemap_srgb_tb;
    import hpt_pkg::*;

    localparam int LIN_W     = 24;
    localparam int NUM_RAND  = 700;
    localparam int MAX_CYC   = 200000;
    localparam int TAIL_CYC  = 40;

    typedef struct packed {
        logic [LIN_W-1:0] r;
        logic [LIN_W-1:0] g;
        logic [LIN_W-1:0] b;
    } t_pixel;

    typedef struct packed {
        logic [CODE_W-1:0] r;
        logic [CODE_W-1:0] g;
        logic [CODE_W-1:0] b;
    } t_codes;

    logic i_clk;
    logic i_rst_n;

    hpt_lin_if #(.WIDTH(LIN_W)) lin_if();
    hpt_code_if                 code_if();

    hdr_pixel_tonemap_srgb dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (lin_if.sink),
        .o_pix  (code_if.source)
    );

    t_pixel pending_px[$];
    t_codes expected_codes[$];
    int     mismatches;
    int     n_sent;
    int     n_recv;
    int     n_sat;
    int     n_lin;
    longint cycles;
    bit     stim_done;
    bit     hold_off;
    int     send_gap;
    int     recv_gap;
    // handshakes seen at the last rising edge
    bit     in_took;
    bit     out_took;

    // m^(5/12) at m = 1 + i/8, Q16
    longint unsigned mant_lut[9] = '{65536, 68832, 71921, 74835, 77598,
                                     80230, 82746, 85159, 87480};
    // 2^(-j/12), Q16
    longint unsigned semi_lut[12] = '{65536, 61858, 58386, 55109, 52016, 49097,
                                      46341, 43740, 41285, 38968, 36781, 34717};

    function automatic longint unsigned aces_q16(input logic [LIN_W-1:0] raw);
        longint unsigned x, s, num, den, q, r;
        x = raw;
        s = 64'd1 << 16;
        if (x >= (s << 3)) return 65536;
        num = x * (251 * x + 3 * s);
        den = x * (243 * x + 59 * s) + 14 * s * s;
        q = num / den;
        r = num - q * den;
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
        end
        return (q > 65536) ? 65536 : q;
    endfunction

    function automatic longint unsigned srgb_code(input logic [LIN_W-1:0] raw);
        longint unsigned y, fr, seg, t, mp, k, p, a, c;
        int e;
        y = aces_q16(raw);
        if (y <= 205) return (y * 329460) / 6553600;
        e = 16;
        while (e > 0 && ((y >> e) & 1) == 0) e--;
        fr = (y << (16 - e)) & 64'hFFFF;
        seg = fr >> 13;
        t = fr & 64'h1FFF;
        mp = mant_lut[seg] + (((mant_lut[seg + 1] - mant_lut[seg]) * t) >> 13);
        k = (16 - e) * 5;
        p = (mp * semi_lut[k % 12]) >> (16 + k / 12);
        a = 1055 * p;
        if (a <= 55 * 65536) return 0;
        c = (255 * (a - 55 * 65536)) / 65536000;
        return (c > 255) ? 255 : c;
    endfunction

    function automatic t_codes tonemap_pixel(input t_pixel px);
        t_codes c;
        c.r = CODE_W'(srgb_code(px.r));
        c.g = CODE_W'(srgb_code(px.g));
        c.b = CODE_W'(srgb_code(px.b));
        return c;
    endfunction

    // bias toward the interesting region: dark, knee, mid, saturating
    function automatic logic [LIN_W-1:0] rand_lin();
        case ($urandom_range(0, 5))
            0:       return LIN_W'($urandom_range(0, 300));
            1:       return LIN_W'($urandom_range(0, 4096));
            2:       return LIN_W'($urandom_range(0, 65536));
            3:       return LIN_W'($urandom_range(0, 600000));
            4:       return LIN_W'($urandom_range(500000, 540000));
            default: return LIN_W'($urandom);
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
    end
    always #1 i_clk = ~i_clk;

    initial begin
        t_pixel px;
        logic [LIN_W-1:0] dir_vals[$];
        dir_vals = '{24'h000000, 24'h000001, 24'h000002, 24'h000040, 24'h0000C0,
                     24'h000800, 24'h004000, 24'h010000, 24'h07FFFF, 24'h080000,
                     24'h080001, 24'h7FFFFF, 24'h800000, 24'hAAAAAA, 24'h555555,
                     24'hFFFFFF};
        foreach (dir_vals[i]) begin
            px.r = dir_vals[i];
            px.g = dir_vals[(i + 5) % dir_vals.size()];
            px.b = dir_vals[(i + 11) % dir_vals.size()];
            pending_px.push_back(px);
        end
        // sweep a few points deep in the linear toe, below the linear/power knee
        for (int v = 0; v < 6; v++) begin
            px.r = LIN_W'(40 + v * 8);
            px.g = LIN_W'(60 + v * 8);
            px.b = LIN_W'(80 + v * 8);
            pending_px.push_back(px);
        end
        for (int i = 0; i < NUM_RAND; i++) begin
            px.r = rand_lin();
            px.g = rand_lin();
            px.b = rand_lin();
            pending_px.push_back(px);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // driver
    initial begin
        lin_if.valid        = 1'b0;
        lin_if.red_linear   = '0;
        lin_if.green_linear = '0;
        lin_if.blue_linear  = '0;
        code_if.ready       = 1'b0;
        send_gap  = 0;
        recv_gap  = 0;
        n_sent    = 0;
        stim_done = 1'b0;
        hold_off  = 1'b0;
        in_took   = 1'b0;
        out_took  = 1'b0;
    end

    always @(negedge i_clk) begin
        t_pixel px;
        int     rg;
        if (i_rst_n) begin
            if (in_took) begin
                n_sent <= n_sent + 1;
                if (n_sent + 1 == 350) hold_off <= 1'b1;
            end
            if (lin_if.valid && !in_took) begin
                // hold the word
            end else if (hold_off && expected_codes.size() == 0 && !lin_if.valid) begin
                hold_off <= 1'b0;
            end else if (hold_off || pending_px.size() == 0) begin
                lin_if.valid <= 1'b0;
                if (pending_px.size() == 0 && !in_took && !lin_if.valid)
                    stim_done <= 1'b1;
                else if (pending_px.size() == 0)
                    stim_done <= 1'b1;
            end else if (send_gap > 0) begin
                lin_if.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else begin
                px = pending_px.pop_front();
                lin_if.valid        <= 1'b1;
                lin_if.red_linear   <= px.r;
                lin_if.green_linear <= px.g;
                lin_if.blue_linear  <= px.b;
                // stretches with no gaps in part of the run
                send_gap <= ((n_sent / 100) % 3 == 1) ? 0 : $urandom_range(0, 8);
            end
            if (out_took) begin
                rg = ((n_recv / 100) % 3 == 2) ? 0 : $urandom_range(0, 8);
                code_if.ready <= (rg == 0);
                recv_gap      <= (rg > 0) ? rg - 1 : 0;
            end else if (recv_gap > 0) begin
                code_if.ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                code_if.ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_codes exp_c;
        t_pixel px;
        in_took  <= i_rst_n && lin_if.valid && lin_if.ready;
        out_took <= i_rst_n && code_if.valid && code_if.ready;
        if (i_rst_n) begin
            if (lin_if.valid && lin_if.ready) begin
                px.r = lin_if.red_linear;
                px.g = lin_if.green_linear;
                px.b = lin_if.blue_linear;
                exp_c = tonemap_pixel(px);
                if (exp_c.r == 255 || exp_c.g == 255 || exp_c.b == 255) n_sat++;
                if (aces_q16(px.r) <= LIN_LIMIT) n_lin++;
                expected_codes.push_back(exp_c);
            end
            if (code_if.valid && code_if.ready) begin
                n_recv++;
                if (expected_codes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output word %h %h %h", code_if.red_code,
                                 code_if.green_code, code_if.blue_code);
                end else begin
                    exp_c = expected_codes.pop_front();
                    if (code_if.red_code !== exp_c.r || code_if.green_code !== exp_c.g ||
                        code_if.blue_code !== exp_c.b) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     n_recv, exp_c.r, exp_c.g, exp_c.b, code_if.red_code,
                                     code_if.green_code, code_if.blue_code);
                    end
                end
            end
        end
    end

    initial begin
        mismatches = 0;
        n_recv = 0;
        n_sat = 0;
        n_lin = 0;
        cycles = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        wait (stim_done && !lin_if.valid);
        wait (expected_codes.size() == 0);
        repeat (TAIL_CYC) @(posedge i_clk);
        $display("%0d pixels in, %0d out; %0d with a saturated channel, %0d red in the linear toe",
                 n_sent, n_recv, n_sat, n_lin);
        if (mismatches == 0 && expected_codes.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
